// File: rtl/core/adsr_envelope_generator_macros.svh
// Assertion macros for the ADSR envelope generator.
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every clock edge out of reset.
`define AEG_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("envelope generator check failed");
// Next-cycle implication, checked on every clock edge out of reset.
`define AEG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("envelope generator check failed");
`else
`define AEG_ASSERT_IMPL(label, ante, cons)
`define AEG_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// File: rtl/core/aeg_pkg.sv
// Shared types and constants of the ADSR envelope generator.
`timescale 1ns / 1ps

package aeg_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int TIME_W     = 24;
    localparam int LEVEL_W    = 16;
    localparam int OPEN_W     = 26;
    localparam int CLOSED_W   = 25;

    // Divider: 16 quotient bits, 24-bit divisor, 40-bit dividend
    localparam int Q_W   = 16;
    localparam int DEN_W = 24;
    localparam int NUM_W = DEN_W + Q_W;
    localparam int CNT_W = $clog2(Q_W + 1);

    localparam int FULL_SCALE = 32768;
    localparam logic [LEVEL_W-1:0]  FULL_SCALE16 = 16'h8000;
    localparam logic [OPEN_W-1:0]   OPEN_MAX     = 26'h3FF_FFFF;
    localparam logic [CLOSED_W-1:0] CLOSED_MAX   = 25'h1FF_FFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRIGGER = 3'd4;

    typedef enum logic [2:0] {
        PH_CLOSED  = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_LDIV_LVL,
        ST_DIV_LVL,
        ST_LEVEL,
        ST_WIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic capture;
        logic eval;
        logic mul;
        logic div_start;
        logic level_take;
        logic win_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } stat_t;

endpackage

// File: rtl/core/aeg_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module aeg_div import aeg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [Q_W-1:0]   quot,
    output logic             done
);

    logic [DEN_W-1:0] rem_reg;
    logic [Q_W-1:0]   shf_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    // The dividend is known to be below den * 2^Q_W, so the top part starts below den
    assign trial = {rem_reg, shf_reg[Q_W-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_W'(Q_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num[NUM_W-1:Q_W];
            shf_reg <= num[Q_W-1:0];
            den_reg <= den;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            shf_reg <= {shf_reg[Q_W-2:0], fits};
        end
    end

    assign quot = shf_reg;
    assign done = (cnt_reg == CNT_W'(1));

endmodule

// File: rtl/core/aeg_ctrl.sv
// Sequencing state machine of the envelope generator.
`timescale 1ns / 1ps

module aeg_ctrl import aeg_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_stall,
    output logic  out_valid,
    input  logic  out_stall,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_EVAL;
            ST_EVAL:     state_next = ST_MUL;
            ST_MUL:      state_next = ST_LDIV_LVL;
            ST_LDIV_LVL: state_next = ST_DIV_LVL;
            ST_DIV_LVL:  if (stat.div_done) state_next = ST_LEVEL;
            ST_LEVEL:    state_next = ST_WIN;
            ST_WIN:      state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        in_stall       = 1'b1;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall    = 1'b0;
                cmd.capture = in_valid;
            end
            ST_EVAL:     cmd.eval = 1'b1;
            ST_MUL:      cmd.mul = 1'b1;
            ST_LDIV_LVL: cmd.div_start = 1'b1;
            ST_LEVEL:    cmd.level_take = 1'b1;
            ST_WIN:      cmd.win_update = 1'b1;
            ST_DONE:
            begin
                cmd.out_load = out_free;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/core/aeg_datapath.sv
// Envelope counters, level arithmetic, smoothing window and result register.
`timescale 1ns / 1ps

module aeg_datapath import aeg_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  gate,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    output logic [LEVEL_W-1:0]    level,
    output logic [2:0]            phase
);

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = $clog2(WINDOW * FULL_SCALE + 1);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);
    // Window average as a multiply by the rounded-up reciprocal; exact for every sum
    localparam int AVG_SHIFT = SUM_W + $clog2(WINDOW);
    localparam int AVG_W     = 2 * SUM_W + 1;
    localparam logic [SUM_W:0] AVG_RECIP =
        (SUM_W + 1)'(((64'd1 << AVG_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Configuration
    logic [TIME_W-1:0]  attack_reg;
    logic [TIME_W-1:0]  decay_reg;
    logic [LEVEL_W-1:0] sustain_reg;
    logic [TIME_W-1:0]  release_reg;
    logic               retrig_reg;

    // Envelope state
    logic                gate_reg;
    logic                is_open_reg;
    logic                is_open_next;
    logic [OPEN_W-1:0]   open_cnt_reg;
    logic [OPEN_W-1:0]   open_cnt_next;
    logic [CLOSED_W-1:0] closed_cnt_reg;
    logic [CLOSED_W-1:0] closed_cnt_next;
    logic [LEVEL_W-1:0]  peak_reg;
    phase_t              phase_reg;
    phase_t              phase_next;

    logic                open_mid;
    logic [OPEN_W-1:0]   oc_mid;
    logic [CLOSED_W-1:0] cc_mid;
    logic                peak_clr;
    logic [TIME_W:0]     ad_sum;

    // Level arithmetic
    logic [LEVEL_W-1:0]       sus_clip;
    logic [OPEN_W-1:0]        oc_off;
    logic [CLOSED_W-1:0]      rel_left;
    logic [LEVEL_W-1:0]       mul_a;
    logic [TIME_W-1:0]        mul_b;
    logic [DEN_W-1:0]         lvl_den;
    logic [NUM_W-1:0]         mul_p;
    logic [NUM_W-1:0]         prod_reg;
    logic [DEN_W-1:0]         lvl_den_reg;
    logic [LEVEL_W-1:0]       level_reg;
    logic [LEVEL_W-1:0]       level_next;

    // Divider
    logic [NUM_W-1:0]   div_num;
    logic [DEN_W-1:0]   div_den;
    logic [Q_W-1:0]     div_q;
    logic               div_done;

    // Smoothing window
    logic [LEVEL_W-1:0] win_mem [0:WINDOW-1];
    logic [LEVEL_W-1:0] rd_data_reg;
    logic [WINDOW-1:0]  valid_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [SUM_W-1:0]   sum_next;
    logic [LEVEL_W-1:0] old_level;
    logic [AVG_W-1:0]   avg_prod;
    logic [LEVEL_W-1:0] avg_q;

    // Result register
    logic [LEVEL_W-1:0] level_out_reg;
    phase_t             phase_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            sustain_reg <= FULL_SCALE16;
            release_reg <= '0;
            retrig_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ATTACK:    attack_reg  <= cfg_data;
                CFG_DECAY:     decay_reg   <= cfg_data;
                CFG_SUSTAIN:   sustain_reg <= cfg_data[LEVEL_W-1:0];
                CFG_RELEASE:   release_reg <= cfg_data;
                CFG_RETRIGGER: retrig_reg  <= cfg_data[0];
                default:       retrig_reg  <= retrig_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            gate_reg <= gate;
        end
    end

    assign ad_sum = {1'b0, attack_reg} + {1'b0, decay_reg};

    // Gate edges first, then advance the running counter and pick the phase
    always_comb
    begin
        open_mid = is_open_reg;
        oc_mid   = open_cnt_reg;
        cc_mid   = closed_cnt_reg;
        peak_clr = 1'b0;
        if (is_open_reg && !gate_reg)
        begin
            open_mid = 1'b0;
            cc_mid   = '0;
        end
        else if (!is_open_reg && gate_reg)
        begin
            if (retrig_reg)
            begin
                oc_mid = '0;
            end
            open_mid = 1'b1;
            peak_clr = 1'b1;
        end

        is_open_next    = open_mid;
        open_cnt_next   = oc_mid;
        closed_cnt_next = cc_mid;
        phase_next      = PH_CLOSED;
        if (open_mid)
        begin
            if (oc_mid != OPEN_MAX)
            begin
                open_cnt_next = oc_mid + OPEN_W'(1);
            end
            phase_next = PH_ATTACK;
            if (open_cnt_next > OPEN_W'(attack_reg))
            begin
                phase_next = PH_DECAY;
            end
            if (open_cnt_next > OPEN_W'(ad_sum))
            begin
                phase_next = PH_SUSTAIN;
            end
        end
        else if (oc_mid != '0)
        begin
            if (cc_mid != CLOSED_MAX)
            begin
                closed_cnt_next = cc_mid + CLOSED_W'(1);
            end
            phase_next = PH_RELEASE;
            if (closed_cnt_next > CLOSED_W'(release_reg))
            begin
                phase_next    = PH_CLOSED;
                open_cnt_next = '0;
            end
        end
    end

    // Operands of the level product and its divisor; a zero-length phase is never selected
    always_comb
    begin
        sus_clip = (sustain_reg > FULL_SCALE16) ? FULL_SCALE16 : sustain_reg;
        oc_off   = open_cnt_reg - OPEN_W'(attack_reg);
        rel_left = CLOSED_W'(release_reg) - closed_cnt_reg;
        case (phase_reg)
            PH_ATTACK:
            begin
                mul_a   = FULL_SCALE16;
                mul_b   = open_cnt_reg[TIME_W-1:0];
                lvl_den = attack_reg;
            end
            PH_DECAY:
            begin
                mul_a   = FULL_SCALE16 - sus_clip;
                mul_b   = oc_off[TIME_W-1:0];
                lvl_den = decay_reg;
            end
            PH_SUSTAIN:
            begin
                mul_a   = sus_clip;
                mul_b   = TIME_W'(1);
                lvl_den = DEN_W'(1);
            end
            PH_RELEASE:
            begin
                mul_a   = peak_reg;
                mul_b   = rel_left[TIME_W-1:0];
                lvl_den = release_reg;
            end
            default:
            begin
                mul_a   = '0;
                mul_b   = '0;
                lvl_den = DEN_W'(1);
            end
        endcase
    end

    assign mul_p = NUM_W'(mul_a) * NUM_W'(mul_b);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg    <= mul_p;
            lvl_den_reg <= lvl_den;
        end
    end

    assign div_num = prod_reg;
    assign div_den = lvl_den_reg;

    aeg_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .quot  (div_q),
        .done  (div_done)
    );

    assign stat.div_done = div_done;

    assign level_next = (phase_reg == PH_DECAY) ? (FULL_SCALE16 - div_q) : div_q;

    always_ff @(posedge clk)
    begin
        if (cmd.level_take)
        begin
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            is_open_reg    <= 1'b0;
            open_cnt_reg   <= '0;
            closed_cnt_reg <= '0;
            peak_reg       <= '0;
            phase_reg      <= PH_CLOSED;
        end
        else if (cmd.eval)
        begin
            is_open_reg    <= is_open_next;
            open_cnt_reg   <= open_cnt_next;
            closed_cnt_reg <= closed_cnt_next;
            phase_reg      <= phase_next;
            if (peak_clr)
            begin
                peak_reg <= '0;
            end
        end
        else if (cmd.level_take && (phase_reg == PH_ATTACK || phase_reg == PH_DECAY ||
                 phase_reg == PH_SUSTAIN))
        begin
            peak_reg <= level_next;
        end
    end

    // Window store: an entry not yet written reads as zero
    always_ff @(posedge clk)
    begin
        if (cmd.win_update)
        begin
            win_mem[slot_reg] <= level_reg;
        end
        rd_data_reg <= win_mem[slot_reg];
    end

    assign old_level = valid_reg[slot_reg] ? rd_data_reg : '0;
    assign sum_next  = sum_reg - SUM_W'(old_level) + SUM_W'(level_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            slot_reg  <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.win_update)
        begin
            valid_reg[slot_reg] <= 1'b1;
            slot_reg            <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + SLOT_W'(1);
            sum_reg             <= sum_next;
        end
    end

    assign avg_prod = AVG_W'(sum_reg) * AVG_W'(AVG_RECIP);
    assign avg_q    = avg_prod[AVG_SHIFT +: LEVEL_W];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            level_out_reg <= avg_q;
            phase_out_reg <= phase_reg;
        end
    end

    assign level = level_out_reg;
    assign phase = phase_out_reg;

endmodule

// File: rtl/core/adsr_envelope_generator.sv
// Top level of the linear ADSR envelope generator with moving-average smoothing.
`timescale 1ns / 1ps
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  ---------------------------------
//  in        sink       in_valid / in_stall     gate
//  out       source     out_valid / out_stall   level (Q1.15), phase
//  cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
//  Each item passes through evaluate, multiply, divider start, division, level
//  capture, window update and result load; the next item is accepted only in idle.
//  The level quotient comes from a 16-step pass of the radix-2 divider; the window
//  average is a reciprocal multiply in the cycle that loads the result register.
//  rst_n is asynchronous and clears control state, counters and window valid bits;
//  configuration returns to attack/decay/release 0, sustain full scale, no retrigger.
//  A stalled output holds in the result register while the next item is accepted;
//  a finished item waits only if the previous result is still untaken.
//  cfg_ready is always high; write configuration only while no item is in flight.
//
`include "adsr_envelope_generator_macros.svh"

module adsr_envelope_generator import aeg_pkg::*;
#(
    parameter int WINDOW = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  gate,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_W-1:0]    level,
    output logic [2:0]            phase,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;
    logic  cfg_we;

    // Registers take a write in any cycle
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // Sequence one item at a time through evaluate, multiply, divide, smooth, average
    aeg_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Hold envelope state, window store and result register
    aeg_datapath #(
        .WINDOW (WINDOW)
    ) u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .gate      (gate),
        .cmd       (cmd),
        .stat      (stat),
        .level     (level),
        .phase     (phase)
    );

    // An accepted item blocks the input for at least the following cycle
    `AEG_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
    // The smoothed level never exceeds full scale
    `AEG_ASSERT_IMPL(a_level_range, out_valid, level <= FULL_SCALE16)
    // A fresh result only appears out of a busy cycle
    `AEG_ASSERT_IMPL(a_result_from_busy, $rose(out_valid), $past(in_stall))

endmodule
